### rtl/sare_pkg.sv
package sare_pkg;

   // Result action codes.
   typedef enum logic [1:0] {
      ACT_TX     = 2'd0,
      ACT_ACK    = 2'd1,
      ACT_APPEND = 2'd2,
      ACT_REFUSE = 2'd3
   } action_type;

   // Which result the datapath loads into the output register.
   typedef enum logic [1:0] {
      RSP_TX,
      RSP_REFUSE,
      RSP_APPEND,
      RSP_ACK
   } rsp_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV0,
      ST_DIV1,
      ST_DIV2,
      ST_REQ,
      ST_CHECK,
      ST_ACK,
      ST_ACKCHK,
      ST_TX0,
      ST_TX1,
      ST_SRD,
      ST_SCMP,
      ST_DATA,
      ST_EMIT_A,
      ST_EMIT_L
   } state_type;

   typedef struct packed {
      logic        capture;
      logic        div0;
      logic        div1;
      logic        div2;
      logic        enqueue;
      logic        ack_advance;
      logic        mul_run;
      logic        mul_head;
      logic        scan_init;
      logic        scan_step;
      logic        scan_cmp;
      logic        tbl_update;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
   } cmd_type;

   typedef struct packed {
      logic in_mode;
      logic refuse;
      logic was_empty;
      logic hdr_bad;
      logic is_ack;
      logic ack_match;
      logic queue_empty;
      logic scan_hit;
      logic scan_last;
      logic data_drop;
      logic data_dup;
   } status_type;

   // Queue entry: segment total, byte count, message number.
   localparam int QE_W  = 72;
   // Table entry: segment total, progress, message number.
   localparam int TE_W  = 64;
   localparam logic [23:0] OFF_MAX = 24'hFFFFFF;
   localparam logic [21:0] SEG_LIMIT = 22'd65535;

endpackage

### rtl/sare_ram.sv
module sare_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sare_ctrl.sv
module sare_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  sare_pkg::status_type status,
   output sare_pkg::cmd_type    cmd
);

   import sare_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_sel = RSP_ACK;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = status.in_mode ? ST_DIV0 : ST_CHECK;
            end
         end
         ST_DIV0: begin
            cmd.div0 = 1'b1;
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            cmd.div1 = 1'b1;
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            cmd.div2 = 1'b1;
            state_in = ST_REQ;
         end
         ST_REQ: begin
            if (status.refuse) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = RSP_REFUSE;
               state_in = ST_EMIT_L;
            end else begin
               cmd.enqueue = 1'b1;
               state_in = status.was_empty ? ST_TX0 : ST_IDLE;
            end
         end
         ST_CHECK: begin
            cmd.mul_run = 1'b1;
            if (status.hdr_bad) begin
               state_in = ST_IDLE;
            end else if (status.is_ack) begin
               state_in = status.ack_match ? ST_ACK : ST_IDLE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in = ST_SRD;
            end
         end
         ST_ACK: begin
            cmd.ack_advance = 1'b1;
            state_in = ST_ACKCHK;
         end
         ST_ACKCHK: begin
            state_in = status.queue_empty ? ST_IDLE : ST_TX0;
         end
         ST_TX0: begin
            cmd.mul_run  = 1'b1;
            cmd.mul_head = 1'b1;
            state_in = ST_TX1;
         end
         ST_TX1: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_sel  = RSP_TX;
            state_in = ST_EMIT_L;
         end
         ST_SRD: begin
            state_in = ST_SCMP;
         end
         ST_SCMP: begin
            cmd.scan_cmp = 1'b1;
            if (status.scan_hit || status.scan_last) begin
               state_in = ST_DATA;
            end else begin
               cmd.scan_step = 1'b1;
               state_in = ST_SRD;
            end
         end
         ST_DATA: begin
            if (status.data_drop) begin
               state_in = ST_IDLE;
            end else if (status.data_dup) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = RSP_ACK;
               state_in = ST_EMIT_L;
            end else begin
               cmd.tbl_update = 1'b1;
               cmd.rsp_load   = 1'b1;
               cmd.rsp_sel    = RSP_APPEND;
               state_in = ST_EMIT_A;
            end
         end
         ST_EMIT_A: begin
            if (!rsp_stall) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = RSP_ACK;
               state_in = ST_EMIT_L;
            end
         end
         ST_EMIT_L: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT_A) || (state_ff == ST_EMIT_L);

endmodule

### rtl/sare_dp.sv
module sare_dp #(
   parameter int PAYLOAD_MAX   = 1024,
   parameter int QUEUE_DEPTH   = 16,
   parameter int REASM_ENTRIES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_mode,
   input  logic [31:0]          req_order,
   input  logic [15:0]          req_segment_index,
   input  logic [15:0]          req_segment_total,
   input  logic [15:0]          req_payload_length,
   input  logic [23:0]          req_message_bytes,
   input  sare_pkg::cmd_type    cmd,
   output sare_pkg::status_type status,
   output logic [1:0]           rsp_action,
   output logic [31:0]          rsp_msg_number,
   output logic [15:0]          rsp_seg_number,
   output logic [15:0]          rsp_seg_count,
   output logic [15:0]          rsp_byte_count,
   output logic [23:0]          rsp_payload_offset,
   output logic                 rsp_message_complete,
   output logic                 rsp_last
);

   import sare_pkg::*;

   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int RAW = (REASM_ENTRIES > 1) ? $clog2(REASM_ENTRIES) : 1;
   localparam logic [15:0] PMAX  = 16'(PAYLOAD_MAX);
   // Reciprocal for the segment count: floor(2^25 / PAYLOAD_MAX).
   localparam logic [21:0] RECIP = 22'((1 << 25) / PAYLOAD_MAX);

   // Captured beat.
   logic        mode_ff;
   logic [31:0] ord_ff;
   logic [15:0] idx_ff;
   logic [15:0] tot_ff;
   logic [15:0] len_ff;
   logic [23:0] mb_ff;

   // Send queue.
   logic [QAW-1:0]  head_ff, tail_ff;
   logic [QCW-1:0]  count_ff;
   logic [15:0]     head_seg_ff;
   logic [QE_W-1:0] q_rd;
   logic [31:0]     q_ord;
   logic [23:0]     q_bytes;
   logic [15:0]     q_tot;

   // Segment count divider.
   logic [24:0] xp;
   logic [46:0] prod_ff;
   logic [21:0] q0;
   logic [37:0] qp_ff;
   logic [37:0] rem;
   logic [21:0] segs_ff;

   // Offset multiplier.
   logic [15:0] mul_a;
   logic [31:0] off_ff;
   logic [23:0] off_sat;
   logic [23:0] tx_len;

   // Reassembly table.
   logic [REASM_ENTRIES-1:0] valid_ff;
   logic [RAW-1:0]  scan_ff;
   logic            hit_ff;
   logic            free_found_ff;
   logic [RAW-1:0]  free_slot_ff;
   logic [RAW-1:0]  tbl_addr;
   logic [TE_W-1:0] t_rd;
   logic [31:0]     t_ord;
   logic [15:0]     t_cur;
   logic [15:0]     t_tot;
   logic            append_done;

   // Output register.
   logic [1:0]  act_ff;
   logic [31:0] msg_ff;
   logic [15:0] seg_ff, cnt_ff, bytes_ff;
   logic [23:0] poff_ff;
   logic        done_ff, last_ff;

   assign q_ord   = q_rd[31:0];
   assign q_bytes = q_rd[55:32];
   assign q_tot   = q_rd[71:56];
   assign t_ord   = t_rd[31:0];
   assign t_cur   = t_rd[47:32];
   assign t_tot   = t_rd[63:48];

   sare_ram #(.WIDTH(QE_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .wr_en   (cmd.enqueue),
      .wr_addr (tail_ff),
      .wr_data ({segs_ff[15:0], mb_ff, ord_ff}),
      .rd_addr (head_ff),
      .rd_data (q_rd)
   );

   assign tbl_addr = hit_ff ? scan_ff : free_slot_ff;

   sare_ram #(.WIDTH(TE_W), .DEPTH(REASM_ENTRIES)) u_table (
      .clock   (clock),
      .wr_en   (cmd.tbl_update),
      .wr_addr (tbl_addr),
      .wr_data ({tot_ff, idx_ff, ord_ff}),
      .rd_addr (scan_ff),
      .rd_data (t_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         ord_ff  <= req_order;
         idx_ff  <= req_segment_index;
         tot_ff  <= req_segment_total;
         len_ff  <= req_payload_length;
         mb_ff   <= req_message_bytes;
      end
   end

   // Ceiling divide by reciprocal; the estimate is low by at most one.
   assign xp  = {1'b0, mb_ff} + 25'(PAYLOAD_MAX - 1);
   assign q0  = prod_ff[46:25];
   assign rem = 38'(xp) - qp_ff;

   always_ff @(posedge clock) begin
      if (cmd.div0) begin
         prod_ff <= 47'(xp) * 47'(RECIP);
      end
      if (cmd.div1) begin
         qp_ff <= 38'(q0) * 38'(PMAX);
      end
      if (cmd.div2) begin
         segs_ff <= (rem >= 38'(PMAX)) ? q0 + 22'd1 : q0;
      end
   end

   assign mul_a = cmd.mul_head ? head_seg_ff - 16'd1 : idx_ff - 16'd1;

   always_ff @(posedge clock) begin
      if (cmd.mul_run) begin
         off_ff <= 32'(mul_a) * 32'(PMAX);
      end
   end

   assign off_sat = (off_ff > 32'(OFF_MAX)) ? OFF_MAX : off_ff[23:0];
   assign tx_len  = (head_seg_ff < q_tot) ? 24'(PMAX) : q_bytes - off_ff[23:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         head_seg_ff <= 16'd1;
      end else begin
         if (cmd.enqueue) begin
            tail_ff  <= (tail_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + QAW'(1);
            count_ff <= count_ff + QCW'(1);
            if (count_ff == '0) begin
               head_seg_ff <= 16'd1;
            end
         end
         if (cmd.ack_advance) begin
            if (head_seg_ff >= q_tot) begin
               head_ff     <= (head_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QAW'(1);
               count_ff    <= count_ff - QCW'(1);
               head_seg_ff <= 16'd1;
            end else begin
               head_seg_ff <= head_seg_ff + 16'd1;
            end
         end
      end
   end

   assign append_done = (idx_ff == tot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.tbl_update) begin
         valid_ff[tbl_addr] <= !append_done;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         scan_ff       <= '0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         if (cmd.scan_step) begin
            scan_ff <= scan_ff + RAW'(1);
         end
         if (cmd.scan_cmp) begin
            if (status.scan_hit) begin
               hit_ff <= 1'b1;
            end
            if (!valid_ff[scan_ff] && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_slot_ff  <= scan_ff;
            end
         end
      end
   end

   always_comb begin
      status.in_mode     = req_mode;
      status.queue_empty = (count_ff == '0);
      status.was_empty   = (count_ff == '0);
      status.refuse      = (mb_ff == '0) || (segs_ff > SEG_LIMIT) ||
                           (count_ff == QCW'(QUEUE_DEPTH));
      status.hdr_bad     = (ord_ff == '0) || (tot_ff == '0) || (idx_ff == '0) ||
                           (idx_ff > tot_ff) || (len_ff > PMAX) || mode_ff;
      status.is_ack      = (len_ff == '0);
      status.ack_match   = (count_ff != '0) && (q_ord == ord_ff) &&
                           (head_seg_ff == idx_ff) && (q_tot == tot_ff);
      status.scan_hit    = valid_ff[scan_ff] && (t_ord == ord_ff);
      status.scan_last   = (scan_ff == RAW'(REASM_ENTRIES - 1));
      if (hit_ff) begin
         status.data_dup  = (t_tot == tot_ff) && (idx_ff <= t_cur);
         status.data_drop = (t_tot != tot_ff) ||
                            ((idx_ff > t_cur) && (idx_ff != t_cur + 16'd1));
      end else begin
         status.data_dup  = 1'b0;
         status.data_drop = (idx_ff != 16'd1) || !free_found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         case (cmd.rsp_sel)
            RSP_TX: begin
               act_ff   <= ACT_TX;
               msg_ff   <= q_ord;
               seg_ff   <= head_seg_ff;
               cnt_ff   <= q_tot;
               bytes_ff <= tx_len[15:0];
               poff_ff  <= off_ff[23:0];
               done_ff  <= 1'b0;
               last_ff  <= 1'b1;
            end
            RSP_REFUSE: begin
               act_ff   <= ACT_REFUSE;
               msg_ff   <= ord_ff;
               seg_ff   <= '0;
               cnt_ff   <= '0;
               bytes_ff <= '0;
               poff_ff  <= '0;
               done_ff  <= 1'b0;
               last_ff  <= 1'b1;
            end
            RSP_APPEND: begin
               act_ff   <= ACT_APPEND;
               msg_ff   <= ord_ff;
               seg_ff   <= idx_ff;
               cnt_ff   <= tot_ff;
               bytes_ff <= len_ff;
               poff_ff  <= off_sat;
               done_ff  <= append_done;
               last_ff  <= 1'b0;
            end
            default: begin
               act_ff   <= ACT_ACK;
               msg_ff   <= ord_ff;
               seg_ff   <= idx_ff;
               cnt_ff   <= tot_ff;
               bytes_ff <= '0;
               poff_ff  <= '0;
               done_ff  <= 1'b0;
               last_ff  <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_action           = act_ff;
   assign rsp_msg_number       = msg_ff;
   assign rsp_seg_number       = seg_ff;
   assign rsp_seg_count        = cnt_ff;
   assign rsp_byte_count       = bytes_ff;
   assign rsp_payload_offset   = poff_ff;
   assign rsp_message_complete = done_ff;
   assign rsp_last             = last_ff;

endmodule

### rtl/segment_ack_reassembly_engine.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  mode, order, segment fields, message_bytes
// rsp_      out        rsp_valid/rsp_stall  action, numbers, counts, offset, flags
//
// One beat is handled at a time. A send request runs the divider, then is refused with
// one result, or queued; into an empty queue it also transmits, with one result. An
// acknowledgement gives one result when a segment follows. A data header scans the
// reassembly table one entry at a time, read then compare, and then gives its results.
// Reset is synchronous; queue pointers and table valid bits are cleared, head segment set to 1.
// A stalled result holds the block until it is taken.
module segment_ack_reassembly_engine #(
   parameter int PAYLOAD_MAX   = 1024,
   parameter int QUEUE_DEPTH   = 16,
   parameter int REASM_ENTRIES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [31:0] req_order,
   input  logic [15:0] req_segment_index,
   input  logic [15:0] req_segment_total,
   input  logic [15:0] req_payload_length,
   input  logic [23:0] req_message_bytes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_action,
   output logic [31:0] rsp_msg_number,
   output logic [15:0] rsp_seg_number,
   output logic [15:0] rsp_seg_count,
   output logic [15:0] rsp_byte_count,
   output logic [23:0] rsp_payload_offset,
   output logic        rsp_message_complete,
   output logic        rsp_last
);

   import sare_pkg::*;

   cmd_type    cmd;
   status_type status;

   sare_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sare_dp #(
      .PAYLOAD_MAX   (PAYLOAD_MAX),
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .REASM_ENTRIES (REASM_ENTRIES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_mode             (req_mode),
      .req_order            (req_order),
      .req_segment_index    (req_segment_index),
      .req_segment_total    (req_segment_total),
      .req_payload_length   (req_payload_length),
      .req_message_bytes    (req_message_bytes),
      .cmd                  (cmd),
      .status               (status),
      .rsp_action           (rsp_action),
      .rsp_msg_number       (rsp_msg_number),
      .rsp_seg_number       (rsp_seg_number),
      .rsp_seg_count        (rsp_seg_count),
      .rsp_byte_count       (rsp_byte_count),
      .rsp_payload_offset   (rsp_payload_offset),
      .rsp_message_complete (rsp_message_complete),
      .rsp_last             (rsp_last)
   );

endmodule

### test/segment_ack_reassembly_engine_test.sv
module segment_ack_reassembly_engine_test;
   import sare_pkg::*;

   localparam int PAYLOAD_MAX   = 1024;
   localparam int QUEUE_DEPTH   = 16;
   localparam int REASM_ENTRIES = 8;
   localparam int RANDOM_ITEMS  = 800;
   localparam int CYCLE_LIMIT   = 600000;

   typedef struct {
      logic        mode;
      logic [31:0] order;
      logic [15:0] seg_index;
      logic [15:0] seg_total;
      logic [15:0] pay_len;
      logic [23:0] msg_bytes;
   } header_beat_type;

   typedef struct {
      action_type  action;
      logic [31:0] msg_number;
      logic [15:0] seg_number;
      logic [15:0] seg_count;
      logic [15:0] byte_count;
      logic [23:0] payload_offset;
      logic        message_complete;
      logic        last;
   } engine_result_type;

   typedef struct {
      header_beat_type   beat;
      bit                typed;
      engine_result_type result;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = 1'b0;
   logic [31:0] req_order = '0;
   logic [15:0] req_segment_index = '0;
   logic [15:0] req_segment_total = '0;
   logic [15:0] req_payload_length = '0;
   logic [23:0] req_message_bytes = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_action;
   logic [31:0] rsp_msg_number;
   logic [15:0] rsp_seg_number;
   logic [15:0] rsp_seg_count;
   logic [15:0] rsp_byte_count;
   logic [23:0] rsp_payload_offset;
   logic        rsp_message_complete;
   logic        rsp_last;

   segment_ack_reassembly_engine dut (.*);

   always #5 clock = ~clock;

   // Shadow state of the engine.
   logic [31:0] sq_order [QUEUE_DEPTH];
   logic [23:0] sq_bytes [QUEUE_DEPTH];
   int          sq_head, sq_tail, sq_count;
   int          head_seg;
   bit          tb_valid [REASM_ENTRIES];
   logic [31:0] tb_order [REASM_ENTRIES];
   logic [15:0] tb_cur [REASM_ENTRIES];
   logic [15:0] tb_tot [REASM_ENTRIES];

   engine_result_type pending_results[$];
   int  mismatches = 0;
   int  cycles = 0;
   bit  quiet = 1'b0;

   function automatic int segs_of(logic [23:0] bytes);
      return (int'(bytes) + PAYLOAD_MAX - 1) / PAYLOAD_MAX;
   endfunction

   function automatic engine_result_type make_result(action_type act, logic [31:0] msg,
         logic [15:0] seg, logic [15:0] cnt, logic [15:0] bytes, logic [23:0] off,
         logic done, logic lst);
      engine_result_type r;
      r.action = act;
      r.msg_number = msg;
      r.seg_number = seg;
      r.seg_count = cnt;
      r.byte_count = bytes;
      r.payload_offset = off;
      r.message_complete = done;
      r.last = lst;
      return r;
   endfunction

   function automatic engine_result_type head_transmit();
      int tot;
      int off;
      int len;
      tot = segs_of(sq_bytes[sq_head]);
      off = (head_seg - 1) * PAYLOAD_MAX;
      len = (head_seg < tot) ? PAYLOAD_MAX : int'(sq_bytes[sq_head]) - off;
      return make_result(ACT_TX, sq_order[sq_head], 16'(head_seg), 16'(tot), 16'(len),
                         24'(off), 1'b0, 1'b1);
   endfunction

   // Advances the shadow state by one beat and returns the results it causes.
   function automatic void compute_engine_results(header_beat_type b,
         ref engine_result_type res[$]);
      int  slot;
      int  off;
      bit  was_empty;
      res = {};
      if (b.mode) begin
         was_empty = (sq_count == 0);
         if (b.msg_bytes == 0 || segs_of(b.msg_bytes) > 65535 || sq_count >= QUEUE_DEPTH) begin
            res.push_back(make_result(ACT_REFUSE, b.order, 0, 0, 0, 0, 1'b0, 1'b1));
            return;
         end
         sq_order[sq_tail] = b.order;
         sq_bytes[sq_tail] = b.msg_bytes;
         sq_tail = (sq_tail + 1) % QUEUE_DEPTH;
         sq_count++;
         if (was_empty) begin
            head_seg = 1;
            res.push_back(head_transmit());
         end
         return;
      end
      if (b.order == 0 || b.seg_total == 0 || b.seg_index == 0 ||
          b.seg_index > b.seg_total || b.pay_len > PAYLOAD_MAX)
         return;
      if (b.pay_len == 0) begin
         if (sq_count == 0) return;
         if (sq_order[sq_head] != b.order || head_seg != b.seg_index ||
             segs_of(sq_bytes[sq_head]) != b.seg_total)
            return;
         head_seg++;
         if (head_seg > segs_of(sq_bytes[sq_head])) begin
            sq_head = (sq_head + 1) % QUEUE_DEPTH;
            sq_count--;
            head_seg = 1;
         end
         if (sq_count != 0) res.push_back(head_transmit());
         return;
      end
      slot = -1;
      for (int i = 0; i < REASM_ENTRIES; i++)
         if (slot < 0 && tb_valid[i] && tb_order[i] == b.order) slot = i;
      off = (int'(b.seg_index) - 1) * PAYLOAD_MAX;
      if (off > 24'hFFFFFF) off = 24'hFFFFFF;
      if (slot < 0) begin
         if (b.seg_index != 1) return;
         for (int i = 0; i < REASM_ENTRIES; i++)
            if (slot < 0 && !tb_valid[i]) slot = i;
         if (slot < 0) return;
         tb_valid[slot] = 1'b1;
         tb_order[slot] = b.order;
         tb_cur[slot] = 16'd1;
         tb_tot[slot] = b.seg_total;
      end else begin
         if (tb_tot[slot] != b.seg_total) return;
         if (b.seg_index <= tb_cur[slot]) begin
            res.push_back(make_result(ACT_ACK, b.order, b.seg_index, b.seg_total, 0, 0,
                                      1'b0, 1'b1));
            return;
         end
         if (b.seg_index != tb_cur[slot] + 1) return;
         tb_cur[slot] = b.seg_index;
      end
      if (tb_cur[slot] == b.seg_total) tb_valid[slot] = 1'b0;
      res.push_back(make_result(ACT_APPEND, b.order, b.seg_index, b.seg_total, b.pay_len,
                                24'(off), tb_cur[slot] == b.seg_total, 1'b0));
      res.push_back(make_result(ACT_ACK, b.order, b.seg_index, b.seg_total, 0, 0,
                                1'b0, 1'b1));
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Drives one beat, waits for it to be taken and records its results.
   task automatic send_beat(header_beat_type b, bit typed, engine_result_type typed_res);
      engine_result_type res[$];
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= b.mode;
      req_order <= b.order;
      req_segment_index <= b.seg_index;
      req_segment_total <= b.seg_total;
      req_payload_length <= b.pay_len;
      req_message_bytes <= b.msg_bytes;
      do @(posedge clock); while (req_stall);
      compute_engine_results(b, res);
      if (typed && res.size() > 0) res[0] = typed_res;
      foreach (res[i]) pending_results.push_back(res[i]);
   endtask

   function automatic header_beat_type hdr(logic mode, logic [31:0] ord, logic [15:0] idx,
         logic [15:0] tot, logic [15:0] len, logic [23:0] bytes);
      header_beat_type b;
      b.mode = mode;
      b.order = ord;
      b.seg_index = idx;
      b.seg_total = tot;
      b.pay_len = len;
      b.msg_bytes = bytes;
      return b;
   endfunction

   function automatic directed_row_type row(header_beat_type b);
      directed_row_type d;
      d.beat = b;
      d.typed = 1'b0;
      d.result = make_result(ACT_TX, 0, 0, 0, 0, 0, 1'b0, 1'b0);
      return d;
   endfunction

   function automatic directed_row_type typed_row(header_beat_type b, engine_result_type r);
      directed_row_type d;
      d.beat = b;
      d.typed = 1'b1;
      d.result = r;
      return d;
   endfunction

   function automatic header_beat_type random_beat();
      header_beat_type b;
      int r;
      int slot;
      int ord;
      b = hdr(1'b0, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
              24'($urandom));
      r = $urandom_range(0, 99);
      if (r < 30) begin
         b.mode = 1'b1;
         // Full-range sizes only when the queue is full, so huge messages get refused.
         if (sq_count < QUEUE_DEPTH) b.msg_bytes = 24'($urandom_range(1, 6 * PAYLOAD_MAX));
         else if ($urandom_range(0, 3) == 0) b.msg_bytes = '0;
      end else if (r < 60) begin
         b.pay_len = '0;
         if (sq_count != 0 && $urandom_range(0, 9) < 8) begin
            b.order = sq_order[sq_head];
            b.seg_index = 16'(head_seg);
            b.seg_total = 16'(segs_of(sq_bytes[sq_head]));
         end else begin
            b.order = $urandom_range(0, 3) ? $urandom_range(1, 20) : 32'd0;
            b.seg_index = 16'($urandom_range(1, 3));
            b.seg_total = 16'($urandom_range(1, 6));
         end
      end else if (r < 92) begin
         ord = $urandom_range(1, 12);
         b.order = 32'(ord);
         b.pay_len = 16'($urandom_range(1, PAYLOAD_MAX));
         slot = -1;
         for (int i = 0; i < REASM_ENTRIES; i++)
            if (slot < 0 && tb_valid[i] && tb_order[i] == ord) slot = i;
         if (slot < 0) begin
            b.seg_index = ($urandom_range(0, 9) == 0) ? 16'd2 : 16'd1;
            b.seg_total = 16'($urandom_range(1, 6));
            if (b.seg_index > b.seg_total) b.seg_total = b.seg_index;
         end else begin
            r = $urandom_range(0, 9);
            b.seg_total = tb_tot[slot];
            if (r < 7) b.seg_index = tb_cur[slot] + 16'd1;
            else if (r < 8) b.seg_index = 16'($urandom_range(1, tb_cur[slot]));
            else if (r < 9) b.seg_index = tb_cur[slot] + 16'd2;
            else b.seg_index = tb_cur[slot] + 16'd1;
            if (r == 9) b.seg_total = tb_tot[slot] + 16'd1;
            if (b.seg_index > b.seg_total) b.seg_index = b.seg_total;
         end
      end else if (r < 96) begin
         // Plausible header with random bit patterns in the size fields.
         b.seg_index = 16'd1;
         b.pay_len = $urandom_range(0, 1) ? 16'(PAYLOAD_MAX + 1) : 16'($urandom);
      end
      return b;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver stalls: runs of random length; no new run starts while the quiet stretch is on.
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (!quiet && $urandom_range(0, 3) == 0)
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
      end
   end

   always @(posedge clock) begin
      engine_result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = make_result(action_type'(rsp_action), rsp_msg_number, rsp_seg_number,
                           rsp_seg_count, rsp_byte_count, rsp_payload_offset,
                           rsp_message_complete, rsp_last);
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: action %0d msg %0h", got.action,
                        got.msg_number);
         end else begin
            want = pending_results.pop_front();
            if (got.action != want.action || got.msg_number != want.msg_number ||
                got.seg_number != want.seg_number || got.seg_count != want.seg_count ||
                got.byte_count != want.byte_count ||
                got.payload_offset != want.payload_offset ||
                got.message_complete != want.message_complete || got.last != want.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected %0d/%0h/%0d/%0d/%0d/%0h/%0b/%0b",
                           want.action, want.msg_number, want.seg_number, want.seg_count,
                           want.byte_count, want.payload_offset, want.message_complete,
                           want.last);
                  $display("          got      %0d/%0h/%0d/%0d/%0d/%0h/%0b/%0b",
                           got.action, got.msg_number, got.seg_number,
                           got.seg_count, got.byte_count, got.payload_offset,
                           got.message_complete, got.last);
               end
            end
         end
      end
   end

   initial begin
      directed_row_type rows[$];
      sq_head = 0;
      sq_tail = 0;
      sq_count = 0;
      head_seg = 1;
      foreach (tb_valid[i]) tb_valid[i] = 1'b0;

      rows.push_back(typed_row(hdr(1, 32'h11, 0, 0, 0, 0),
                               make_result(ACT_REFUSE, 32'h11, 0, 0, 0, 0, 0, 1)));
      rows.push_back(typed_row(hdr(1, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1),
                               make_result(ACT_TX, 32'hFFFFFFFF, 1, 1, 1, 0, 0, 1)));
      rows.push_back(row(hdr(0, 5, 1, 1, 0, 0)));
      rows.push_back(row(hdr(0, 32'hFFFFFFFF, 1, 1, 0, 24'hFFFFFF)));
      rows.push_back(row(hdr(0, 32'hFFFFFFFF, 1, 1, 0, 0)));
      rows.push_back(typed_row(hdr(1, 2, 0, 0, 0, 3000),
                               make_result(ACT_TX, 2, 1, 3, PAYLOAD_MAX, 0, 0, 1)));
      rows.push_back(row(hdr(1, 3, 0, 0, 0, PAYLOAD_MAX)));
      rows.push_back(row(hdr(0, 2, 1, 3, 0, 0)));
      rows.push_back(row(hdr(0, 2, 2, 3, 0, 0)));
      rows.push_back(row(hdr(0, 2, 3, 3, 0, 0)));
      rows.push_back(row(hdr(0, 3, 1, 1, 0, 0)));
      rows.push_back(row(hdr(0, 0, 1, 1, 10, 0)));
      rows.push_back(row(hdr(0, 7, 3, 2, 10, 0)));
      rows.push_back(row(hdr(0, 7, 1, 1, PAYLOAD_MAX + 1, 0)));
      rows.push_back(row(hdr(0, 7, 0, 1, 10, 0)));
      rows.push_back(row(hdr(0, 9, 2, 3, 10, 0)));
      rows.push_back(row(hdr(0, 9, 1, 3, PAYLOAD_MAX, 0)));
      rows.push_back(row(hdr(0, 9, 1, 3, 5, 0)));
      rows.push_back(row(hdr(0, 9, 3, 3, 5, 0)));
      rows.push_back(row(hdr(0, 9, 2, 4, 5, 0)));
      rows.push_back(row(hdr(0, 9, 2, 3, 1, 0)));
      rows.push_back(row(hdr(0, 9, 3, 3, 7, 0)));
      rows.push_back(row(hdr(0, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, PAYLOAD_MAX, 0)));
      // Eight open messages fill the table, so the ninth new one is dropped.
      for (int i = 0; i < REASM_ENTRIES + 1; i++)
         rows.push_back(row(hdr(0, 32'(100 + i), 1, 2, 16, 0)));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_beat(rows[i].beat, rows[i].typed, rows[i].result);
      // Close the eight open messages again.
      for (int i = 0; i < REASM_ENTRIES; i++)
         send_beat(hdr(0, 32'(100 + i), 2, 2, 16, 0), 1'b0, rows[0].result);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = ((n / 100) % 3 == 1);
         send_beat(random_beat(), 1'b0, rows[0].result);
      end
      req_valid <= 1'b0;
      quiet = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### files.f
rtl/sare_pkg.sv
rtl/sare_ram.sv
rtl/sare_ctrl.sv
rtl/sare_dp.sv
rtl/segment_ack_reassembly_engine.sv
test/segment_ack_reassembly_engine_test.sv
